>>> sv/amstep_pkg.sv
package amstep_pkg;

  localparam int IMEM_WORDS  = 128;
  localparam int DMEM_WORDS  = 11;
  localparam int DATA_WIDTH  = 32;
  localparam int IAW         = $clog2(IMEM_WORDS);
  localparam int DAW         = $clog2(DMEM_WORDS);
  localparam int DRESET_WORD = 10;

  typedef logic [7:0]                   pc_t;
  typedef logic [7:0]                   byte_t;
  typedef logic signed [DATA_WIDTH-1:0] word_t;

  localparam byte_t OP_LOAD  = 8'd1;
  localparam byte_t OP_ADD   = 8'd2;
  localparam byte_t OP_STORE = 8'd3;
  localparam byte_t OP_SUB   = 8'd4;
  localparam byte_t OP_IN    = 8'd5;
  localparam byte_t OP_OUT   = 8'd6;
  localparam byte_t OP_HALT  = 8'd7;
  localparam byte_t OP_JMP   = 8'd8;
  localparam byte_t OP_SKIPZ = 8'd9;
  localparam byte_t OP_SKIPG = 8'd10;
  localparam byte_t OP_SKIPL = 8'd11;

  typedef enum logic [1:0] {
    ST_OK,
    ST_HALT,
    ST_BAD_ADDR,
    ST_PAST_END
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DATA,
    S_EXEC
  } seq_state_t;

  typedef struct packed {
    logic               step;
    logic signed [31:0] in_value;
    byte_t              opcode;
    byte_t              addr;
    pc_t                pc;
    word_t              acc;
    logic               halted;
    word_t              dmem_word;
  } exec_in_t;

  typedef struct packed {
    pc_t     pc_next;
    word_t   acc_next;
    logic    halt_next;
    logic    dmem_we;
    logic    out_valid;
    status_t status;
  } exec_out_t;

  // data store contents after reset
  function automatic word_t dmem_reset_value(byte_t addr);
    word_t v;
    v = '0;
    if (DRESET_WORD < DMEM_WORDS && addr == 8'(DRESET_WORD)) begin
      v = word_t'(1);
    end
    return v;
  endfunction

endpackage

>>> sv/amstep_in_if.sv
interface amstep_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [6:0]         load_index;
  logic [7:0]         load_value;
  logic signed [31:0] in_value;

  modport source (output valid, operation, load_index, load_value, in_value, input ready);
  modport sink (input valid, operation, load_index, load_value, in_value, output ready);
endinterface

>>> sv/amstep_out_if.sv
interface amstep_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         pc_now;
  logic signed [31:0] acc_now;
  logic               out_valid;
  logic [1:0]         status;

  modport source (output valid, pc_now, acc_now, out_valid, status, input ready);
  modport sink (input valid, pc_now, acc_now, out_valid, status, output ready);
endinterface

>>> sv/amstep_ram.sv
module amstep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/amstep_exec.sv
module amstep_exec (
  input  amstep_pkg::exec_in_t  x,
  output amstep_pkg::exec_out_t y
);
  import amstep_pkg::*;

  logic addr_ok;
  logic acc_neg;

  assign addr_ok = x.addr < 8'(DMEM_WORDS);
  assign acc_neg = x.acc[DATA_WIDTH-1];

  always_comb begin
    y.pc_next   = x.pc;
    y.acc_next  = x.acc;
    y.halt_next = x.halted;
    y.dmem_we   = 1'b0;
    y.out_valid = 1'b0;
    y.status    = ST_OK;
    if (!x.step) begin
      y.status = x.halted ? ST_HALT : ST_OK;
    end else if (x.halted) begin
      y.status = ST_HALT;
    end else if ({1'b0, x.pc} >= 9'(IMEM_WORDS)) begin
      y.status = ST_PAST_END;
    end else begin
      y.pc_next = x.pc + 8'd2;
      case (x.opcode)
        OP_LOAD, OP_ADD, OP_STORE, OP_SUB: begin
          if (!addr_ok) begin
            y.status = ST_BAD_ADDR;
          end else begin
            case (x.opcode)
              OP_LOAD:  y.acc_next = x.dmem_word;
              OP_ADD:   y.acc_next = x.acc + x.dmem_word;
              OP_SUB:   y.acc_next = x.acc - x.dmem_word;
              OP_STORE: y.dmem_we = 1'b1;
              default:  y.acc_next = x.acc;
            endcase
          end
        end
        OP_IN:   y.acc_next = DATA_WIDTH'(x.in_value);
        OP_OUT:  y.out_valid = 1'b1;
        OP_HALT: begin
          y.halt_next = 1'b1;
          y.status    = ST_HALT;
        end
        OP_JMP:  y.pc_next = x.addr;
        OP_SKIPZ: begin
          if (x.acc == '0) y.pc_next = x.pc + 8'd4;
        end
        OP_SKIPG: begin
          if (x.acc != '0 && !acc_neg) y.pc_next = x.pc + 8'd4;
        end
        OP_SKIPL: begin
          if (acc_neg) y.pc_next = x.pc + 8'd4;
        end
        default: y.pc_next = x.pc + 8'd2;
      endcase
    end
  end
endmodule

>>> sv/accumulator_machine_step_core.sv
// channel  dir  payload                                          handshake
// cmd      in   operation, load_index, load_value, in_value      valid/ready
// res      out  pc_now, acc_now, out_valid, status               valid/ready
//
// an item reaches the result register in this order: instruction
// store read at acceptance, then data store read, then execute; the next item can be
// accepted in the execute stage once the result slot is free, while the last item executes
// reset clears the valid bits of both stores at once, so items are taken right away
// a result that is not taken holds the execute stage and with it the input
module accumulator_machine_step_core (
  input logic         clk,
  input logic         rst,
  amstep_in_if.sink   cmd,
  amstep_out_if.source res
);
  import amstep_pkg::*;

  seq_state_t state, state_next;

  pc_t                 pc;
  word_t               acc;
  logic                halted;
  logic                step_q;
  logic signed [31:0]  in_value_q;
  logic                addr_past;
  byte_t               opcode_q;
  byte_t               addr_q;

  logic [IMEM_WORDS-1:0] ivld;
  logic                  ivld_a;
  logic                  ivld_b;
  logic [DMEM_WORDS-1:0] dvld;
  logic                  dvld_rd;

  logic      in_acc;
  logic      out_free;
  logic      exec_done;
  logic      capture;
  pc_t       fetch_pc;
  logic [8:0] fetch_pc1;
  byte_t     ia_rd;
  byte_t     ib_rd;
  byte_t     op_word;
  byte_t     addr_word;
  byte_t     dsel;
  word_t     d_rd;
  logic      dwe;
  logic      iwe;
  logic [IAW-1:0] iwa;
  exec_in_t  xi;
  exec_out_t xo;

  assign in_acc    = cmd.valid && cmd.ready;
  assign out_free  = !res.valid || res.ready;
  assign fetch_pc  = (state == S_EXEC) ? xo.pc_next : pc;
  assign fetch_pc1 = {1'b0, fetch_pc} + 9'd1;
  assign iwe       = in_acc && !cmd.operation;
  assign iwa       = IAW'(cmd.load_index);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_acc) state_next = S_DATA;
      S_DATA:  state_next = S_EXEC;
      S_EXEC:  if (out_free) state_next = in_acc ? S_DATA : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    exec_done = 1'b0;
    capture   = 1'b0;
    cmd.ready = 1'b0;
    case (state)
      S_IDLE: cmd.ready = 1'b1;
      S_DATA: capture = 1'b1;
      S_EXEC: begin
        exec_done = out_free;
        cmd.ready = out_free;
      end
      default: cmd.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pc     <= '0;
      acc    <= '0;
      halted <= 1'b0;
      ivld   <= '0;
      dvld   <= '0;
    end else begin
      state <= state_next;
      if (exec_done) begin
        pc     <= xo.pc_next;
        acc    <= xo.acc_next;
        halted <= xo.halt_next;
      end
      if (iwe) ivld[iwa] <= 1'b1;
      if (dwe) dvld[addr_q[DAW-1:0]] <= 1'b1;
    end
  end

  // instruction store kept twice so opcode and address word come in one read
  amstep_ram #(.WIDTH(8), .DEPTH(IMEM_WORDS)) u_imem_op (
    .clk   (clk),
    .we    (iwe),
    .waddr (iwa),
    .wdata (cmd.load_value),
    .raddr (fetch_pc[IAW-1:0]),
    .rdata (ia_rd)
  );

  amstep_ram #(.WIDTH(8), .DEPTH(IMEM_WORDS)) u_imem_addr (
    .clk   (clk),
    .we    (iwe),
    .waddr (iwa),
    .wdata (cmd.load_value),
    .raddr (fetch_pc1[IAW-1:0]),
    .rdata (ib_rd)
  );

  always_ff @(posedge clk) begin
    ivld_a <= ivld[fetch_pc[IAW-1:0]];
    ivld_b <= ivld[fetch_pc1[IAW-1:0]];
    if (in_acc) begin
      step_q     <= cmd.operation;
      in_value_q <= cmd.in_value;
      addr_past  <= fetch_pc1 >= 9'(IMEM_WORDS);
    end
    if (capture) begin
      opcode_q <= op_word;
      addr_q   <= addr_word;
    end
  end

  assign op_word   = ivld_a ? ia_rd : '0;
  assign addr_word = (addr_past || !ivld_b) ? '0 : ib_rd;
  // hold the data read address while the execute stage stalls
  assign dsel      = capture ? addr_word : addr_q;
  assign dwe       = exec_done && xo.dmem_we;

  amstep_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DMEM_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dwe),
    .waddr (addr_q[DAW-1:0]),
    .wdata (acc),
    .raddr (dsel[DAW-1:0]),
    .rdata (d_rd)
  );

  always_ff @(posedge clk) begin
    dvld_rd <= dvld[dsel[DAW-1:0]];
  end

  assign xi.step      = step_q;
  assign xi.in_value  = in_value_q;
  assign xi.opcode    = opcode_q;
  assign xi.addr      = addr_q;
  assign xi.pc        = pc;
  assign xi.acc       = acc;
  assign xi.halted    = halted;
  assign xi.dmem_word = dvld_rd ? d_rd : dmem_reset_value(addr_q);

  amstep_exec u_exec (
    .x (xi),
    .y (xo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (exec_done) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      res.pc_now    <= xo.pc_next;
      res.acc_now   <= 32'(xo.acc_next);
      res.out_valid <= xo.out_valid;
      res.status    <= xo.status;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("halt flag cleared without reset");
  a_no_store_halted: assert property (@(posedge clk) disable iff (rst) halted |-> !dwe)
    else $error("data store written while halted");
  a_store_in_range: assert property (@(posedge clk) disable iff (rst)
    dwe |-> addr_q < 8'(DMEM_WORDS))
    else $error("data store written at bad address");
  a_accept_to_data: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == S_DATA)
    else $error("accepted item did not enter the data stage");
endmodule
